>>> hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Echo ranger package
// Widths, register codes, reset values and the command and status bundles
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package uer_pkg;

   // Most samples averaged in one reading.
   localparam int MAX_SAMPLES = 4;

   // Field and register widths.
   localparam int TICK_W   = 16;
   localparam int TRIG_W   = 8;
   localparam int DIST_W   = 17;
   localparam int SAMP_W   = 3;
   localparam int VCNT_W   = 3;
   localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int TGT_W    = SAMP_W + 1;
   localparam int SUM_W    = DIST_W + $clog2(MAX_SAMPLES);
   localparam int ADDR_W   = 3;
   localparam int CSR_W    = 17;
   localparam int DIV_N_W  = $clog2(SUM_W);

   // Distance scale: d = (duration * 281) >> 6, in 1/256 cm.
   localparam int MUL_W      = 9;
   localparam int DIST_MUL   = 281;
   localparam int DIST_SHIFT = 6;
   localparam int PROD_W     = TICK_W + MUL_W;

   // Stream words.
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 24;
   localparam int START_BIT = 0;
   localparam int ECHO_BIT  = 1;

   // Register reset values.
   localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST  = 8'd10;
   localparam logic [TICK_W-1:0] ECHO_TMO_RST    = 16'd30000;
   localparam logic [TICK_W-1:0] GAP_RST         = 16'd50000;
   localparam logic [TICK_W-1:0] MIN_ECHO_RST    = 16'd100;
   localparam logic [TICK_W-1:0] MAX_ECHO_RST    = 16'd23270;
   localparam logic [DIST_W-1:0] MIN_DIST_RST    = 17'd512;
   localparam logic [DIST_W-1:0] MAX_DIST_RST    = 17'd102400;
   localparam logic [SAMP_W-1:0] SAMPLES_RST     = 3'd3;

   // Register indexes on the csr port.
   typedef enum logic [ADDR_W-1:0] {
      REG_TRIG_WIDTH = 3'd0,
      REG_ECHO_TMO   = 3'd1,
      REG_GAP        = 3'd2,
      REG_MIN_ECHO   = 3'd3,
      REG_MAX_ECHO   = 3'd4,
      REG_MIN_DIST   = 3'd5,
      REG_MAX_DIST   = 3'd6,
      REG_SAMPLES    = 3'd7
   } csr_index_type;

   // Tick counter update selected by the controller.
   typedef enum logic [1:0] {
      TC_HOLD  = 2'd0,
      TC_CLEAR = 2'd1,
      TC_ONE   = 2'd2,
      TC_INC   = 2'd3
   } tc_op_type;

   typedef struct packed {
      tc_op_type tc_op;
      logic      clr_run;
      logic      latch_dur;
      logic      idx_inc;
      logic      out_tick;
      logic      trig;
      logic      busy;
      logic      mul;
      logic      judge;
      logic      div_load;
      logic      div_step;
      logic      out_final;
   } cmd_type;

   typedef struct packed {
      logic gap_hit;
      logic tw_le1;
      logic trig_hit;
      logic tmo_hit;
      logic last_sample;
      logic out_free;
      logic div_last;
   } status_type;

endpackage

>>> hdl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Runs a trigger and echo timing sequence per sample and reports the mean
// distance over the accepted samples of one reading.
// ----------------------------------------------------------------------------
// Latency: an ordinary tick gives its word in the cycle after it is accepted.
// A tick that ends a sample on a falling echo then holds off input for the
// distance multiply and the range check and accumulate. A tick that ends a
// reading adds the divider load, the bit-serial divide and the result write.
// Throughput: one tick per cycle unless a sample ends on a falling echo, a tick
// ends a reading or the output word waits for the consumer. Reset is synchronous;
// it restores the register defaults and leaves the ranger idle.
module ultrasonic_echo_ranger (
   input  logic                        clock,
   input  logic                        reset,
   // Tick input. tdata, from bit 0 up: start_req, echo, then zero padding.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [uer_pkg::REQ_W-1:0]   req_tdata,
   // Result output. tdata, from bit 0 up: trigger, busy_res, done_res,
   // distance_q8[16:0], valid_count[2:0], no_echo.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [uer_pkg::RSP_W-1:0]   rsp_tdata,
   // Register write port.
   input  logic                        csr_we,
   input  logic [uer_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [uer_pkg::CSR_W-1:0]   csr_wdata
);
   import uer_pkg::*;

   // The controller steps the ranging phase once per accepted tick and walks
   // the datapath through the judgment and the divide while input is held off.
   cmd_type    cmd;
   status_type status;

   uer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the registers, counters, multiplier, divider and the
   // output word register that lets a result wait for the consumer.
   uer_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hdl/uer_datapath.sv
// ----------------------------------------------------------------------------
// Echo ranger datapath
// Configuration registers, tick counter, distance multiplier, accumulator,
// bit-serial averaging divider and the result register.
// ----------------------------------------------------------------------------
module uer_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [uer_pkg::ADDR_W-1:0]   csr_addr,
   input  logic [uer_pkg::CSR_W-1:0]    csr_wdata,
   input  uer_pkg::cmd_type             cmd,
   output uer_pkg::status_type          status,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [uer_pkg::RSP_W-1:0]    rsp_tdata
);
   import uer_pkg::*;

   logic [TRIG_W-1:0] trig_width_ff, trig_width_in;
   logic [TICK_W-1:0] echo_tmo_ff, echo_tmo_in;
   logic [TICK_W-1:0] gap_ff, gap_in;
   logic [TICK_W-1:0] min_echo_ff, min_echo_in;
   logic [TICK_W-1:0] max_echo_ff, max_echo_in;
   logic [DIST_W-1:0] min_dist_ff, min_dist_in;
   logic [DIST_W-1:0] max_dist_ff, max_dist_in;
   logic [SAMP_W-1:0] samples_ff, samples_in;

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W:0]   tick_inc;
   logic [TICK_W-1:0] dur_ff, dur_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              dur_ok_ff, dur_ok_in;

   logic [PROD_W-DIST_SHIFT-1:0] dist_raw;
   logic [DIST_W-1:0]            dist_sat;
   logic                         dist_ok;

   logic [TGT_W-1:0] samp_ext;
   logic [TGT_W-1:0] target;
   logic [TGT_W-1:0] idx_next;

   logic [SUM_W-1:0]   div_q_ff, div_q_in;
   logic [CNT_W-1:0]   div_r_ff, div_r_in;
   logic [DIV_N_W-1:0] div_n_ff, div_n_in;
   logic [CNT_W:0]     div_sh;
   logic [CNT_W:0]     div_diff;
   logic               div_ge;

   logic             out_valid_ff, out_valid_in;
   logic [RSP_W-1:0] out_data_ff, out_data_in;
   logic [DIST_W-1:0] mean;

   // Configuration writes.
   always_comb begin
      trig_width_in = trig_width_ff;
      echo_tmo_in   = echo_tmo_ff;
      gap_in        = gap_ff;
      min_echo_in   = min_echo_ff;
      max_echo_in   = max_echo_ff;
      min_dist_in   = min_dist_ff;
      max_dist_in   = max_dist_ff;
      samples_in    = samples_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            REG_TRIG_WIDTH: trig_width_in = csr_wdata[TRIG_W-1:0];
            REG_ECHO_TMO:   echo_tmo_in   = csr_wdata[TICK_W-1:0];
            REG_GAP:        gap_in        = csr_wdata[TICK_W-1:0];
            REG_MIN_ECHO:   min_echo_in   = csr_wdata[TICK_W-1:0];
            REG_MAX_ECHO:   max_echo_in   = csr_wdata[TICK_W-1:0];
            REG_MIN_DIST:   min_dist_in   = csr_wdata[DIST_W-1:0];
            REG_MAX_DIST:   max_dist_in   = csr_wdata[DIST_W-1:0];
            REG_SAMPLES:    samples_in    = csr_wdata[SAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Tick counter and sample bookkeeping.
   assign tick_inc = {1'b0, tick_ff} + 1'b1;

   always_comb begin
      case (cmd.tc_op)
         TC_CLEAR: tick_in = '0;
         TC_ONE:   tick_in = TICK_W'(1);
         TC_INC:   tick_in = tick_inc[TICK_W-1:0];
         default:  tick_in = tick_ff;
      endcase
   end

   assign dur_in = cmd.latch_dur ? tick_ff : dur_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clr_run) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Sample count is read live; zero acts as one and it saturates at the maximum.
   assign samp_ext = TGT_W'(samples_ff);
   always_comb begin
      if (samples_ff == '0) begin
         target = TGT_W'(1);
      end else if (samp_ext > TGT_W'(MAX_SAMPLES)) begin
         target = TGT_W'(MAX_SAMPLES);
      end else begin
         target = samp_ext;
      end
   end
   assign idx_next = TGT_W'(idx_ff) + 1'b1;

   // First stage of a sample's judgment: scale the duration and check its range.
   assign prod_in   = cmd.mul ? PROD_W'(dur_ff) * PROD_W'(DIST_MUL) : prod_ff;
   assign dur_ok_in = cmd.mul ? (dur_ff >= min_echo_ff && dur_ff <= max_echo_ff) : dur_ok_ff;

   // Second stage: saturate the distance, check its range and accumulate.
   assign dist_raw = prod_ff[PROD_W-1:DIST_SHIFT];
   assign dist_sat = (|dist_raw[PROD_W-DIST_SHIFT-1:DIST_W]) ? '1 : dist_raw[DIST_W-1:0];
   assign dist_ok  = dur_ok_ff && dist_sat >= min_dist_ff && dist_sat <= max_dist_ff;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (cmd.clr_run) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (cmd.judge && dist_ok) begin
         sum_in = sum_ff + SUM_W'(dist_sat);
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Restoring divider, one quotient bit per cycle, MSB first.
   assign div_sh   = {div_r_ff, div_q_ff[SUM_W-1]};
   assign div_ge   = div_sh >= {1'b0, cnt_ff};
   assign div_diff = div_sh - {1'b0, cnt_ff};

   always_comb begin
      div_q_in = div_q_ff;
      div_r_in = div_r_ff;
      div_n_in = div_n_ff;
      if (cmd.div_load) begin
         div_q_in = sum_ff;
         div_r_in = '0;
         div_n_in = DIV_N_W'(SUM_W - 1);
      end else if (cmd.div_step) begin
         div_q_in = {div_q_ff[SUM_W-2:0], div_ge};
         div_r_in = div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
         div_n_in = div_n_ff - 1'b1;
      end
   end

   // Result register.
   assign mean = div_q_ff[DIST_W-1:0];

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (cmd.out_tick) begin
         out_valid_in = 1'b1;
         out_data_in  = {1'b0, VCNT_W'(0), DIST_W'(0), 1'b0, cmd.busy, cmd.trig};
      end else if (cmd.out_final) begin
         out_valid_in = 1'b1;
         if (cnt_ff == '0) begin
            out_data_in = {1'b1, VCNT_W'(0), DIST_W'(0), 1'b1, 1'b0, 1'b0};
         end else begin
            out_data_in = {1'b0, VCNT_W'(cnt_ff), mean, 1'b1, 1'b0, 1'b0};
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_width_ff <= TRIG_WIDTH_RST;
         echo_tmo_ff   <= ECHO_TMO_RST;
         gap_ff        <= GAP_RST;
         min_echo_ff   <= MIN_ECHO_RST;
         max_echo_ff   <= MAX_ECHO_RST;
         min_dist_ff   <= MIN_DIST_RST;
         max_dist_ff   <= MAX_DIST_RST;
         samples_ff    <= SAMPLES_RST;
         tick_ff       <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         sum_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         trig_width_ff <= trig_width_in;
         echo_tmo_ff   <= echo_tmo_in;
         gap_ff        <= gap_in;
         min_echo_ff   <= min_echo_in;
         max_echo_ff   <= max_echo_in;
         min_dist_ff   <= min_dist_in;
         max_dist_ff   <= max_dist_in;
         samples_ff    <= samples_in;
         tick_ff       <= tick_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         sum_ff        <= sum_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff      <= dur_in;
      prod_ff     <= prod_in;
      dur_ok_ff   <= dur_ok_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_n_ff    <= div_n_in;
      out_data_ff <= out_data_in;
   end

   // Tick count is zero as gap, rise and high phases start, so raw compares hold.
   assign status.gap_hit     = tick_ff >= gap_ff;
   assign status.tw_le1      = trig_width_ff <= TRIG_W'(1);
   assign status.trig_hit    = tick_inc >= (TICK_W + 1)'(trig_width_ff);
   assign status.tmo_hit     = tick_inc >= {1'b0, echo_tmo_ff};
   assign status.last_sample = idx_next >= target;
   assign status.out_free    = !out_valid_ff || rsp_tready;
   assign status.div_last    = div_n_ff == '0;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> hdl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// Echo ranger controller
// Ranging phase sequencer and the step sequencer that runs the judgment and
// the averaging divide between ticks.
// ----------------------------------------------------------------------------
module uer_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [uer_pkg::REQ_W-1:0]  req_tdata,
   input  uer_pkg::status_type        status,
   output uer_pkg::cmd_type           cmd
);
   import uer_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_GAP  = 5'b00010,
      PH_TRIG = 5'b00100,
      PH_RISE = 5'b01000,
      PH_HIGH = 5'b10000
   } phase_type;

   typedef enum logic [5:0] {
      ST_TICK  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_JUDGE = 6'b000100,
      ST_DLOAD = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_FIN   = 6'b100000
   } step_type;

   phase_type phase_ff, phase_in, ph_next;
   step_type  step_ff, step_in;
   logic      final_ff, final_in;

   logic      start, echo, accept;
   logic      start_go, in_gap, gap_exit, in_trig, trig_done;
   logic      sample_end, ok, last_end;
   tc_op_type tc_op;

   assign start      = req_tdata[START_BIT];
   assign echo       = req_tdata[ECHO_BIT];
   assign req_tready = (step_ff == ST_TICK) && status.out_free;
   assign accept     = req_tvalid && req_tready;

   // Next ranging phase for the current tick. A start and an expired gap both
   // fall through into the following phase on the same tick.
   assign start_go = (phase_ff == PH_IDLE) && start;
   assign in_gap   = start_go || (phase_ff == PH_GAP);
   assign gap_exit = in_gap && status.gap_hit;
   assign in_trig  = gap_exit || (phase_ff == PH_TRIG);

   always_comb begin
      ph_next    = phase_ff;
      tc_op      = TC_HOLD;
      sample_end = 1'b0;
      ok         = 1'b0;
      trig_done  = gap_exit ? status.tw_le1 : status.trig_hit;
      if (in_trig) begin
         if (trig_done) begin
            ph_next = PH_RISE;
            tc_op   = TC_CLEAR;
         end else begin
            ph_next = PH_TRIG;
            tc_op   = gap_exit ? TC_ONE : TC_INC;
         end
      end else if (in_gap) begin
         ph_next = PH_GAP;
         tc_op   = TC_INC;
      end else if (phase_ff == PH_RISE) begin
         if (echo) begin
            ph_next = PH_HIGH;
            tc_op   = TC_CLEAR;
         end else begin
            tc_op      = TC_INC;
            sample_end = status.tmo_hit;
         end
      end else if (phase_ff == PH_HIGH) begin
         if (!echo) begin
            sample_end = 1'b1;
            ok         = 1'b1;
         end else begin
            tc_op      = TC_INC;
            sample_end = status.tmo_hit;
         end
      end
      if (sample_end) begin
         tc_op   = TC_CLEAR;
         ph_next = status.last_sample ? PH_IDLE : PH_GAP;
      end
   end

   assign last_end = sample_end && status.last_sample;

   always_comb begin
      cmd      = '0;
      cmd.tc_op = TC_HOLD;
      phase_in = phase_ff;
      step_in  = step_ff;
      final_in = final_ff;
      unique case (step_ff)
         ST_TICK: begin
            if (accept) begin
               cmd.tc_op     = tc_op;
               cmd.clr_run   = start_go;
               cmd.latch_dur = ok;
               cmd.idx_inc   = sample_end;
               cmd.trig      = in_trig;
               cmd.busy      = ph_next != PH_IDLE;
               cmd.out_tick  = !last_end;
               phase_in      = ph_next;
               final_in      = last_end;
               if (ok) begin
                  step_in = ST_MUL;
               end else if (last_end) begin
                  step_in = ST_DLOAD;
               end
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            step_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            cmd.judge = 1'b1;
            step_in   = final_ff ? ST_DLOAD : ST_TICK;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            step_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               step_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.out_final = 1'b1;
            step_in       = ST_TICK;
         end
         default: begin
            step_in = ST_TICK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= ST_TICK;
         final_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         final_ff <= final_in;
      end
   end

endmodule
